[rtl/fdcrc8_pkg.sv]
package fdcrc8_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;

   localparam logic [1:0] ST_GOOD        = 2'd0;
   localparam logic [1:0] ST_BAD_VERSION = 2'd1;
   localparam logic [1:0] ST_TOO_LONG    = 2'd2;
   localparam logic [1:0] ST_BAD_CRC     = 2'd3;

   localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_EXP_VERSION = 2'd2;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] version;
   } cfg_type;

   // One finished frame (or error) handed from parser to emitter
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] msg_type;
      logic [5:0] payload_len;
      logic       bank;
   } frame_desc_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] msg_type;
      logic [5:0] payload_len;
      logic       has_byte;
      logic [4:0] byte_index;
      logic [7:0] payload_byte;
      logic       last;
   } rsp_beat_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/fdcrc8_req_if.sv]
interface fdcrc8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/fdcrc8_rsp_if.sv]
interface fdcrc8_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] msg_type;
   logic [5:0] payload_len;
   logic       has_byte;
   logic [4:0] byte_index;
   logic [7:0] payload_byte;
   logic       last;

   modport source (output valid, output status, output msg_type, output payload_len,
                   output has_byte, output byte_index, output payload_byte,
                   output last, input ready);
   modport sink (input valid, input status, input msg_type, input payload_len,
                 input has_byte, input byte_index, input payload_byte,
                 input last, output ready);
endinterface

[rtl/fdcrc8_ram.sv]
module fdcrc8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fdcrc8_queue.sv]
module fdcrc8_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fdcrc8_pkg::frame_desc_type push_desc,
   input  logic                     pop,
   output fdcrc8_pkg::frame_desc_type head,
   output logic                     empty,
   output logic                     full
);

   fdcrc8_pkg::frame_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

endmodule

[rtl/fdcrc8_front.sv]
module fdcrc8_front (
   input  logic                       clock,
   input  logic                       reset,
   input  fdcrc8_pkg::cfg_type        cfg,
   input  logic                       in_valid,
   input  logic [7:0]                 in_byte,
   output logic                       in_ready,
   input  logic                       q_full,
   output logic                       q_push,
   output fdcrc8_pkg::frame_desc_type q_desc,
   output fdcrc8_pkg::ram_wr_type     ram_wr
);

   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_VER   = 3'd2;
   localparam logic [2:0] PH_TYPE  = 3'd3;
   localparam logic [2:0] PH_LEN   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CRC   = 3'd6;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] type_ff, type_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] taken_ff, taken_in;
   logic       bank_ff, bank_in;
   logic       accept;
   logic [7:0] crc_next;
   logic [5:0] taken_inc;

   assign in_ready  = !q_full;
   assign accept    = in_valid && !q_full;
   assign crc_next  = fdcrc8_pkg::crc8_feed(crc_ff, in_byte);
   assign taken_inc = taken_ff + 6'd1;

   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      taken_in = taken_ff;
      bank_in  = bank_ff;
      q_push   = 1'b0;
      q_desc   = '0;
      ram_wr   = '0;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (in_byte == cfg.sync_first) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (in_byte == cfg.sync_second) begin
                  phase_in = PH_VER;
               end else if (in_byte != cfg.sync_first) begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_VER: begin
               if (in_byte == cfg.version) begin
                  crc_in   = fdcrc8_pkg::crc8_feed(fdcrc8_pkg::CRC_INIT, in_byte);
                  phase_in = PH_TYPE;
               end else begin
                  // a bad version that matches the first sync byte reopens the hunt
                  phase_in      = (in_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
                  q_push        = 1'b1;
                  q_desc.status = fdcrc8_pkg::ST_BAD_VERSION;
               end
            end
            PH_TYPE: begin
               type_in  = in_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (in_byte > 8'(fdcrc8_pkg::MAX_PAYLOAD)) begin
                  phase_in      = PH_SYNC1;
                  q_push        = 1'b1;
                  q_desc.status = fdcrc8_pkg::ST_TOO_LONG;
               end else begin
                  len_in   = in_byte[5:0];
                  taken_in = 6'd0;
                  crc_in   = crc_next;
                  phase_in = (in_byte == 8'd0) ? PH_CRC : PH_DATA;
               end
            end
            PH_DATA: begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = {bank_ff, taken_ff[fdcrc8_pkg::IDX_W-1:0]};
               ram_wr.data = in_byte;
               crc_in      = crc_next;
               taken_in    = taken_inc;
               if (taken_inc >= len_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               phase_in = PH_SYNC1;
               q_push   = 1'b1;
               if (in_byte != crc_ff) begin
                  q_desc.status = fdcrc8_pkg::ST_BAD_CRC;
               end else begin
                  q_desc.status      = fdcrc8_pkg::ST_GOOD;
                  q_desc.msg_type    = type_ff;
                  q_desc.payload_len = len_ff;
                  q_desc.bank        = bank_ff;
                  // hand this bank to the emitter, fill the other one next
                  if (len_ff != 6'd0) begin
                     bank_in = !bank_ff;
                  end
               end
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff   <= crc_in;
      type_ff  <= type_in;
      len_ff   <= len_in;
      taken_ff <= taken_in;
   end

endmodule

[rtl/fdcrc8_back.sv]
module fdcrc8_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  fdcrc8_pkg::frame_desc_type          q_head,
   output logic                                q_pop,
   output logic                                rd_en,
   output logic [fdcrc8_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [7:0]                          rd_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output fdcrc8_pkg::rsp_beat_type            out_beat
);

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_READ = 2'd1;
   localparam logic [1:0] BK_SHOW = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [fdcrc8_pkg::IDX_W-1:0]   idx_ff, idx_in;
   fdcrc8_pkg::rsp_beat_type       beat_ff, beat_in;
   logic [fdcrc8_pkg::IDX_W-1:0]   idx_inc;
   logic                           idx_is_last;

   assign idx_inc     = idx_ff + fdcrc8_pkg::IDX_W'(1);
   assign idx_is_last = (({1'b0, idx_ff} + (fdcrc8_pkg::IDX_W + 1)'(1))
                         == (fdcrc8_pkg::IDX_W + 1)'(q_head.payload_len));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      beat_in  = beat_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = {q_head.bank, idx_ff};
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if ((q_head.status != fdcrc8_pkg::ST_GOOD) ||
                   (q_head.payload_len == 6'd0)) begin
                  // single beat: error status or empty good frame
                  beat_in        = '0;
                  beat_in.status = q_head.status;
                  beat_in.last   = 1'b1;
                  if (q_head.status == fdcrc8_pkg::ST_GOOD) begin
                     beat_in.msg_type = q_head.msg_type;
                  end
                  state_in = BK_SHOW;
               end else begin
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = {q_head.bank, {fdcrc8_pkg::IDX_W{1'b0}}};
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            beat_in.status       = fdcrc8_pkg::ST_GOOD;
            beat_in.msg_type     = q_head.msg_type;
            beat_in.payload_len  = q_head.payload_len;
            beat_in.has_byte     = 1'b1;
            beat_in.byte_index   = 5'(idx_ff);
            beat_in.payload_byte = rd_data;
            beat_in.last         = idx_is_last;
            state_in             = BK_SHOW;
         end
         BK_SHOW: begin
            if (out_ready) begin
               if (beat_ff.last) begin
                  q_pop    = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  rd_en    = 1'b1;
                  rd_addr  = {q_head.bank, idx_inc};
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      beat_ff <= beat_in;
   end

   assign out_valid = (state_ff == BK_SHOW);
   assign out_beat  = beat_ff;

endmodule

[rtl/frame_deframer_crc8.sv]
// Byte-stream deframer: hunts for two sync bytes, checks the version, takes type, length
// (up to 32), payload and a CRC-8 (poly 0x07, init 0) over version..payload. A good
// frame yields one beat per payload byte (one beat for an empty payload), last marking
// the final one; a version, length or CRC error yields one status beat. The parser takes
// one input beat per cycle and stalls only while the two-entry frame queue is full, that
// is while two finished frames or error reports wait to be sent (the one being sent
// counts), which the two payload banks in the 64-byte RAM match. The emitter reads each
// payload byte from the RAM, registers it into a result beat and holds that beat on the
// output until it is taken; only then does it read the next byte. A status beat or an
// empty good frame is registered straight from the queue head instead. Configuration
// registers sit at byte addresses 0, 4 and 8 and should be written only while idle.
module frame_deframer_crc8 (
   input  logic                clock,
   input  logic                reset,
   fdcrc8_req_if.sink          req_chan,
   fdcrc8_rsp_if.source        rsp_chan,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   fdcrc8_pkg::cfg_type         cfg_ff, cfg_in;
   logic                        csr_wr;
   logic [1:0]                  csr_index;
   logic                        q_push, q_pop, q_empty, q_full;
   fdcrc8_pkg::frame_desc_type  q_desc, q_head;
   fdcrc8_pkg::ram_wr_type      ram_wr;
   logic                        rd_en;
   logic [fdcrc8_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                  rd_data;
   fdcrc8_pkg::rsp_beat_type    beat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            fdcrc8_pkg::REG_SYNC_FIRST:  cfg_in.sync_first  = csr_pwdata[7:0];
            fdcrc8_pkg::REG_SYNC_SECOND: cfg_in.sync_second = csr_pwdata[7:0];
            fdcrc8_pkg::REG_EXP_VERSION: cfg_in.version     = csr_pwdata[7:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fdcrc8_pkg::REG_SYNC_FIRST:  csr_prdata = {24'd0, cfg_ff.sync_first};
         fdcrc8_pkg::REG_SYNC_SECOND: csr_prdata = {24'd0, cfg_ff.sync_second};
         fdcrc8_pkg::REG_EXP_VERSION: csr_prdata = {24'd0, cfg_ff.version};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= 8'hAA;
         cfg_ff.sync_second <= 8'h55;
         cfg_ff.version     <= 8'h01;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fdcrc8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_chan.valid),
      .in_byte  (req_chan.rx_byte),
      .in_ready (req_chan.ready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (q_desc),
      .ram_wr   (ram_wr)
   );

   fdcrc8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   fdcrc8_ram #(
      .WIDTH (8),
      .DEPTH (fdcrc8_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fdcrc8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_beat  (beat)
   );

   assign rsp_chan.status       = beat.status;
   assign rsp_chan.msg_type     = beat.msg_type;
   assign rsp_chan.payload_len  = beat.payload_len;
   assign rsp_chan.has_byte     = beat.has_byte;
   assign rsp_chan.byte_index   = beat.byte_index;
   assign rsp_chan.payload_byte = beat.payload_byte;
   assign rsp_chan.last         = beat.last;

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("frame queue pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("frame queue popped while empty");

   a_data_only_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.has_byte) |-> (rsp_chan.status == fdcrc8_pkg::ST_GOOD))
      else $error("payload beat carries an error status");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != fdcrc8_pkg::ST_GOOD))
         |-> (rsp_chan.last && !rsp_chan.has_byte))
      else $error("error status beat not single and last");

endmodule

[tb/sv/deframe_checker.sv]
module deframe_checker
   import fdcrc8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fdcrc8_req_if       req_mon,
   fdcrc8_rsp_if       rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      WANT_VERSION,
      WANT_TYPE,
      WANT_LENGTH,
      TAKE_PAYLOAD,
      WANT_CRC
   } parse_phase_type;

   localparam logic [7:0] SYNC_FIRST_AT_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_AT_RESET = 8'h55;
   localparam logic [7:0] VERSION_AT_RESET     = 8'h01;

   logic [7:0]      sync_first;
   logic [7:0]      sync_second;
   logic [7:0]      version_req;
   parse_phase_type phase;
   logic [7:0]      crc_acc;
   logic [7:0]      held_type;
   logic [5:0]      held_len;
   logic [5:0]      taken;
   logic [7:0]      payload_mem [MAX_PAYLOAD];
   rsp_beat_type    expected_beats [$];

   // bit-serial form of the MSB-first CRC-8
   function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[7] ^ b[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   function automatic rsp_beat_type status_beat(logic [1:0] st);
      rsp_beat_type beat;
      beat        = '0;
      beat.status = st;
      beat.last   = 1'b1;
      return beat;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      rsp_beat_type beat;
      int i;
      case (phase)
         HUNT_FIRST: begin
            if (b == sync_first) phase = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            if (b == sync_second) phase = WANT_VERSION;
            else if (b != sync_first) phase = HUNT_FIRST;
         end
         WANT_VERSION: begin
            if (b == version_req) begin
               crc_acc = crc8_step(CRC_INIT, b);
               phase   = WANT_TYPE;
            end else begin
               // a bad version equal to the first sync byte opens a new header
               phase = (b == sync_first) ? HUNT_SECOND : HUNT_FIRST;
               expected_beats.push_back(status_beat(ST_BAD_VERSION));
            end
         end
         WANT_TYPE: begin
            held_type = b;
            crc_acc   = crc8_step(crc_acc, b);
            phase     = WANT_LENGTH;
         end
         WANT_LENGTH: begin
            if (b > MAX_PAYLOAD) begin
               phase = HUNT_FIRST;
               expected_beats.push_back(status_beat(ST_TOO_LONG));
            end else begin
               held_len = b[5:0];
               taken    = '0;
               crc_acc  = crc8_step(crc_acc, b);
               phase    = (b == 8'd0) ? WANT_CRC : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            payload_mem[taken[4:0]] = b;
            crc_acc = crc8_step(crc_acc, b);
            taken   = taken + 6'd1;
            if (taken >= held_len) phase = WANT_CRC;
         end
         WANT_CRC: begin
            phase = HUNT_FIRST;
            if (b != crc_acc) begin
               expected_beats.push_back(status_beat(ST_BAD_CRC));
            end else if (held_len == 6'd0) begin
               beat          = status_beat(ST_GOOD);
               beat.msg_type = held_type;
               expected_beats.push_back(beat);
            end else begin
               for (i = 0; i < held_len; i++) begin
                  beat.status       = ST_GOOD;
                  beat.msg_type     = held_type;
                  beat.payload_len  = held_len;
                  beat.has_byte     = 1'b1;
                  beat.byte_index   = i[4:0];
                  beat.payload_byte = payload_mem[i];
                  beat.last         = (i + 1 == held_len);
                  expected_beats.push_back(beat);
               end
            end
         end
         default: phase = HUNT_FIRST;
      endcase
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (reset) begin
         sync_first  = SYNC_FIRST_AT_RESET;
         sync_second = SYNC_SECOND_AT_RESET;
         version_req = VERSION_AT_RESET;
         phase       = HUNT_FIRST;
         crc_acc     = CRC_INIT;
         held_type   = '0;
         held_len    = '0;
         taken       = '0;
         fail_count  = 0;
         expected_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SYNC_FIRST:  sync_first  = csr_pwdata[7:0];
               REG_SYNC_SECOND: sync_second = csr_pwdata[7:0];
               REG_EXP_VERSION: version_req = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: status %0d type %0d",
                      rsp_mon.status, rsp_mon.msg_type);
               fail_count++;
            end else begin
               exp_beat = expected_beats.pop_front();
               check_field("status", exp_beat.status, rsp_mon.status);
               check_field("msg_type", exp_beat.msg_type, rsp_mon.msg_type);
               check_field("payload_len", exp_beat.payload_len, rsp_mon.payload_len);
               check_field("has_byte", exp_beat.has_byte, rsp_mon.has_byte);
               check_field("byte_index", exp_beat.byte_index, rsp_mon.byte_index);
               check_field("payload_byte", exp_beat.payload_byte, rsp_mon.payload_byte);
               check_field("last", exp_beat.last, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready) deframe_byte(req_mon.rx_byte);
      end
      pending = expected_beats.size();
   end

endmodule

[tb/sv/tb_frame_deframer_crc8.sv]
module tb_frame_deframer_crc8;
   import fdcrc8_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_BYTES  = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          bytes_sent  = 0;
   bit          steady       = 1'b0;
   bit          hold_request = 1'b0;
   logic [7:0]  cfg_first   = 8'hAA;
   logic [7:0]  cfg_second  = 8'h55;
   logic [7:0]  cfg_version = 8'h01;

   fdcrc8_req_if req_if ();
   fdcrc8_rsp_if rsp_if ();

   frame_deframer_crc8 DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   deframe_checker deframe_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == cfg_first);
      return b;
   endfunction

   function automatic logic [7:0] rand_len();
      int r;
      r = $urandom_range(99);
      if (r < 85) return 8'($urandom_range(8));
      if (r < 97) return 8'($urandom_range(31, 9));
      return 8'(MAX_PAYLOAD);
   endfunction

   // header, then stop where the block would bail out
   function automatic void add_frame(ref logic [7:0] q[$], input logic [7:0] version,
                                     input logic [7:0] msg_type, input logic [7:0] len_byte,
                                     input logic [7:0] crc_flip);
      logic [7:0] crc;
      logic [7:0] b;
      q.push_back(cfg_first);
      q.push_back(cfg_second);
      q.push_back(version);
      if (version != cfg_version) return;
      q.push_back(msg_type);
      q.push_back(len_byte);
      if (len_byte > MAX_PAYLOAD) return;
      crc = crc8_feed(crc8_feed(crc8_feed(CRC_INIT, version), msg_type), len_byte);
      for (int i = 0; i < len_byte; i++) begin
         b   = 8'($urandom);
         crc = crc8_feed(crc, b);
         q.push_back(b);
      end
      q.push_back(crc ^ crc_flip);
   endfunction

   function automatic void random_frame(ref logic [7:0] q[$]);
      int         pick;
      int         len;
      int         keep;
      logic [7:0] v;
      if ($urandom_range(99) < 15) repeat ($urandom_range(3, 1)) q.push_back(noise_byte());
      if ($urandom_range(99) < 15) repeat ($urandom_range(2, 1)) q.push_back(cfg_first);
      pick = $urandom_range(99);
      if (pick < 60) begin
         add_frame(q, cfg_version, 8'($urandom), rand_len(), 8'h00);
      end else if (pick < 70) begin
         add_frame(q, cfg_version, 8'($urandom), rand_len(), 8'($urandom_range(255, 1)));
      end else if (pick < 78) begin
         if (cfg_first != cfg_version && $urandom_range(2) == 0) v = cfg_first;
         else do v = 8'($urandom); while (v == cfg_version);
         add_frame(q, v, 8'h00, 8'h00, 8'h00);
      end else if (pick < 86) begin
         add_frame(q, cfg_version, 8'($urandom), 8'($urandom_range(255, 33)), 8'h00);
      end else if (pick < 93) begin
         repeat ($urandom_range(6, 1)) q.push_back(noise_byte());
      end else begin
         // cut frame: short payload, then flush with bytes other than the first sync byte
         len  = $urandom_range(8, 1);
         keep = $urandom_range(len - 1);
         q.push_back(cfg_first);
         q.push_back(cfg_second);
         q.push_back(cfg_version);
         q.push_back(8'($urandom));
         q.push_back(8'(len));
         repeat (keep) q.push_back(8'($urandom));
         repeat (len + 2) q.push_back(noise_byte());
      end
   endfunction

   task automatic send_byte(input logic [7:0] value);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_bytes(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i]);
      q.delete();
   endtask

   // let the checker see the last byte sent before reading the count
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves psel high so back-to-back writes need no release in between
   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SYNC_FIRST:  cfg_first   = value;
         REG_SYNC_SECOND: cfg_second  = value;
         REG_EXP_VERSION: cfg_version = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] first, input logic [7:0] second,
                            input logic [7:0] version);
      drain_results();
      csr_write(REG_SYNC_FIRST, first);
      csr_write(REG_SYNC_SECOND, second);
      csr_write(REG_EXP_VERSION, version);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [7:0] frame_q [$];
      int         phase_start;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_frame(frame_q, cfg_version, 8'h00, 8'd0, 8'h00);
      add_frame(frame_q, 8'h02, 8'h00, 8'h00, 8'h00);
      frame_q.push_back(cfg_first);
      add_frame(frame_q, cfg_version, 8'hFF, 8'd1, 8'h00);
      add_frame(frame_q, cfg_first, 8'h00, 8'h00, 8'h00);
      add_frame(frame_q, cfg_version, 8'h5A, 8'd33, 8'h00);
      add_frame(frame_q, cfg_version, 8'h3C, 8'd2, 8'h80);
      send_bytes(frame_q);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: configure(8'hAA, 8'h55, 8'h01);
            1: configure(8'h00, 8'hFF, 8'h00);
            2: configure(8'hFF, 8'h00, 8'hFF);
            default: configure(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         if (p == 0) begin
            add_frame(frame_q, cfg_version, 8'($urandom), 8'(MAX_PAYLOAD), 8'h00);
            send_bytes(frame_q);
         end
         if (p == 1) begin
            // hold off results while frames keep coming, then wait them out
            hold_request = 1'b1;
            repeat (3) add_frame(frame_q, cfg_version, 8'($urandom), 8'd12, 8'h00);
            send_bytes(frame_q);
            drain_results();
         end
         steady      = (p == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if (bytes_sent - phase_start >= PHASE_BYTES / 2) steady = 1'b0;
            random_frame(frame_q);
            send_bytes(frame_q);
         end
         steady = 1'b0;
      end

      drain_results();
      if (fail_count == 0 && pending == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
